// ----- hdl/dcmap_pkg.sv -----
package dcmap_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int SLOT_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam int VOLT_W = 15;
  localparam int CURR_W = 16;
  localparam int POWER_W = 31;

  // running sums grow by the log of the depth
  localparam int VSUM_W = VOLT_W + SLOT_W;
  localparam int CSUM_W = CURR_W + SLOT_W + 1;

  // serial divider covers the wider of the two sums
  localparam int DIV_W = CSUM_W;
  localparam int ITER_W = $clog2(DIV_W);

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV_V,
    S_DIV_C,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [CURR_W-1:0] curr;
  } sample_t;

endpackage

// ----- hdl/dual_channel_moving_average_power.sv -----
// an online sample passes through read, update, two divider passes and a multiply; an offline one goes to the result
// a new input is taken only in idle, after the last result is loaded; two 20-step divider passes per online sample
// the single-port window memory is read in its own state before the sum update
// rst (synchronous, active high) clears slot pointer, full flag, sums and handshake state
// window memory is not cleared: a slot is only read back after it has been written
module dual_channel_moving_average_power (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [14:0] bus_voltage_mv, [30:15] current_ma, [31] zero fill
  input  logic [dcmap_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] sensor_online, [1] restart
  input  logic [dcmap_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] avg_voltage_mv, [30:15] avg_current_ma, [61:31] power_uw, [63:62] zero fill
  output logic [dcmap_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] valid_res
  output logic [dcmap_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import dcmap_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIV_W - 1);

  state_t state, state_next;

  // window memory, voltage and current share one slot
  sample_t mem [WINDOW_DEPTH];
  sample_t mem_rd;
  logic    mem_we;

  // captured input transaction
  logic [VOLT_W-1:0]        in_volt;
  logic signed [CURR_W-1:0] in_curr;

  // history
  logic [SLOT_W-1:0]        write_slot;
  logic                     window_full;
  logic [VSUM_W-1:0]        vsum;
  logic signed [CSUM_W-1:0] csum;
  logic [COUNT_W-1:0]       count;

  // sum update terms
  logic [VSUM_W-1:0]        vsum_next;
  logic signed [CSUM_W-1:0] csum_next;
  logic [SLOT_W-1:0]        slot_inc;
  logic                     full_next;

  // shared serial divider
  logic [DIV_W-1:0]   quo;
  logic [COUNT_W-1:0] rem;
  logic [ITER_W-1:0]  iter;
  logic [COUNT_W:0]   rem_sh;
  logic               div_ge;
  logic [COUNT_W:0]   rem_sub;
  logic [DIV_W-1:0]   quo_next;
  logic [DIV_W-1:0]   cmag;
  logic               c_neg;

  // result registers
  logic [VOLT_W-1:0]         avg_v;
  logic signed [CURR_W-1:0]  avg_c;
  logic signed [POWER_W-1:0] power;
  logic                      res_valid;
  logic signed [2*CURR_W-1:0] prod;

  // handshake control
  logic s_accept;
  logic in_online;
  logic in_restart;
  logic out_load;

  assign in_online  = s_axis_tuser[0];
  assign in_restart = s_axis_tuser[1];
  assign s_accept   = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = in_online ? S_READ : S_DONE;
        end
      end
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_DIV_V;
      S_DIV_V:  if (iter == LAST_ITER) state_next = S_DIV_C;
      S_DIV_C:  if (iter == LAST_ITER) state_next = S_MUL;
      S_MUL:    state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_UPDATE: mem_we = 1'b1;
      S_DONE:   out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window memory with registered read at the current slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_slot] <= '{volt: in_volt, curr: in_curr};
    end
    mem_rd <= mem[write_slot];
  end

  // oldest sample leaves only once the window has wrapped
  always_comb begin
    vsum_next = vsum + VSUM_W'(in_volt);
    csum_next = csum + CSUM_W'(in_curr);
    if (window_full) begin
      vsum_next = vsum_next - VSUM_W'(mem_rd.volt);
      csum_next = csum_next - CSUM_W'($signed(mem_rd.curr));
    end
    slot_inc  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
    full_next = window_full || (write_slot == LAST_SLOT);
  end

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    div_ge   = rem_sh >= {1'b0, count};
    rem_sub  = div_ge ? rem_sh - {1'b0, count} : rem_sh;
    quo_next = {quo[DIV_W-2:0], div_ge};
  end

  assign prod = $signed({1'b0, avg_v}) * avg_c;

  // history and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      window_full <= 1'b0;
      vsum        <= '0;
      csum        <= '0;
    end else begin
      if (state == S_IDLE && s_accept && in_online && in_restart) begin
        write_slot  <= '0;
        window_full <= 1'b0;
        vsum        <= '0;
        csum        <= '0;
      end
      if (state == S_UPDATE) begin
        write_slot  <= slot_inc;
        window_full <= full_next;
        vsum        <= vsum_next;
        csum        <= csum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          in_volt   <= s_axis_tdata[VOLT_W-1:0];
          in_curr   <= s_axis_tdata[VOLT_W+CURR_W-1:VOLT_W];
          res_valid <= in_online;
          avg_v     <= '0;
          avg_c     <= '0;
          power     <= '0;
        end
      end
      S_UPDATE: begin
        count <= full_next ? COUNT_W'(WINDOW_DEPTH) : COUNT_W'(slot_inc);
        quo   <= DIV_W'(vsum_next);
        rem   <= '0;
        iter  <= '0;
        c_neg <= csum_next[CSUM_W-1];
        cmag  <= csum_next[CSUM_W-1] ? DIV_W'(-csum_next) : DIV_W'(csum_next);
      end
      S_DIV_V: begin
        iter <= iter + 1'b1;
        if (iter == LAST_ITER) begin
          avg_v <= quo_next[VOLT_W-1:0];
          quo   <= cmag;
          rem   <= '0;
          iter  <= '0;
        end else begin
          quo <= quo_next;
          rem <= rem_sub[COUNT_W-1:0];
        end
      end
      S_DIV_C: begin
        iter <= iter + 1'b1;
        quo  <= quo_next;
        rem  <= rem_sub[COUNT_W-1:0];
        if (iter == LAST_ITER) begin
          // truncation toward zero: divide the magnitude, restore the sign
          avg_c <= c_neg ? -$signed(quo_next[CURR_W-1:0]) : $signed(quo_next[CURR_W-1:0]);
        end
      end
      S_MUL: begin
        power <= prod[POWER_W-1:0];
      end
      default: begin
        iter <= iter;
      end
    endcase
  end

  // output register, parts the result from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(M_TDATA_W - VOLT_W - CURR_W - POWER_W){1'b0}}, power, avg_c, avg_v};
      m_axis_tuser <= res_valid;
    end
  end

`ifndef ASSERT_OFF
  // divider remainder never reaches the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_V || state == S_DIV_C) |-> (rem < count))
    else $error("divider remainder not below sample count");

  // sample count is never zero once the divider runs
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |=> (count != '0))
    else $error("zero sample count after window update");

  // an offline sample leaves the history untouched
  a_offline_hold: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !in_online) |=> ($stable(write_slot) && $stable(window_full)
                                  && $stable(vsum) && $stable(csum)))
    else $error("offline sample changed window history");

  // an invalid result carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("offline result has nonzero fields");
`endif

endmodule

// ----- sim/tb.sv -----
module tb;
  import dcmap_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct {
    logic [VOLT_W-1:0]         avg_volt;
    logic signed [CURR_W-1:0]  avg_curr;
    logic signed [POWER_W-1:0] power;
    logic                      valid;
  } power_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // averaging history kept by the testbench
  int volt_hist [WINDOW_DEPTH];
  int curr_hist [WINDOW_DEPTH];
  int hist_slot;
  bit hist_full;
  int hist_vsum;
  int hist_csum;

  power_result_t pending_results [$];
  int mismatch_count;
  int cycle_count;
  int stall_left;
  bit no_idle;

  dual_channel_moving_average_power i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side backpressure, with an occasional long stall
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 2) begin
      stall_left <= $urandom_range(60, 1);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 200)
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // windowed means and power for one sample, updates the local history
  function automatic power_result_t predict_power(input logic [VOLT_W-1:0] volt,
                                                  input logic signed [CURR_W-1:0] curr,
                                                  input bit online, input bit clear_hist);
    power_result_t r;
    int slot;
    int count;
    int avg_v;
    int avg_i;
    r.avg_volt = '0;
    r.avg_curr = '0;
    r.power = '0;
    r.valid = 1'b0;
    // offline: history untouched, restart ignored, all fields zero
    if (!online)
      return r;
    if (clear_hist) begin
      hist_slot = 0;
      hist_full = 1'b0;
      hist_vsum = 0;
      hist_csum = 0;
    end
    slot = hist_slot;
    // a full window drops the oldest sample at the slot being overwritten
    if (hist_full) begin
      hist_vsum -= volt_hist[slot];
      hist_csum -= curr_hist[slot];
    end
    volt_hist[slot] = int'(volt);
    curr_hist[slot] = int'(curr);
    hist_vsum += volt_hist[slot];
    hist_csum += curr_hist[slot];
    slot++;
    if (slot >= WINDOW_DEPTH) begin
      slot = 0;
      hist_full = 1'b1;
    end
    hist_slot = slot;
    count = hist_full ? WINDOW_DEPTH : hist_slot;
    // integer division truncates toward zero
    avg_v = hist_vsum / count;
    avg_i = hist_csum / count;
    r.avg_volt = avg_v[VOLT_W-1:0];
    r.avg_curr = avg_i[CURR_W-1:0];
    r.power = POWER_W'(avg_v * avg_i);
    r.valid = 1'b1;
    return r;
  endfunction

  // one input transaction, with a random gap ahead of it
  task automatic send_sample(input logic [VOLT_W-1:0] volt, input logic signed [CURR_W-1:0] curr,
                             input bit online, input bit clear_hist);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(99) < 4)
        gap = $urandom_range(70, 1);
      else
        while ($urandom_range(99) < 31) gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, curr, volt};
    s_axis_tuser <= {clear_hist, online};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(predict_power(volt, curr, online, clear_hist));
  endtask

  // result checker
  always @(posedge clk) begin
    power_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[14:0] !== want.avg_volt)
          report_mismatch("avg_voltage_mv", m_axis_tdata[14:0], want.avg_volt);
        if (m_axis_tdata[30:15] !== want.avg_curr)
          report_mismatch("avg_current_ma", $signed(m_axis_tdata[30:15]), want.avg_curr);
        if (m_axis_tdata[61:31] !== want.power)
          report_mismatch("power_uw", $signed(m_axis_tdata[61:31]), want.power);
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("valid_res", m_axis_tuser[0], want.valid);
      end
    end
  end

  // field extremes, first sample after reset, window fill and wrap
  task automatic test_extremes();
    send_sample(15'd32767, -16'sd32768, 1'b1, 1'b0);
    repeat (8) send_sample(15'd32767, -16'sd32768, 1'b1, 1'b0);
    send_sample(15'd32767, 16'sd32767, 1'b1, 1'b0);
    send_sample(15'd0, 16'sd32767, 1'b1, 1'b0);
    send_sample(15'd0, 16'sd0, 1'b1, 1'b0);
    send_sample(15'd16384, -16'sd1, 1'b1, 1'b0);
  endtask

  // offline samples leave the history alone and ignore restart
  task automatic test_offline();
    send_sample(15'd32767, 16'sd32767, 1'b0, 1'b1);
    send_sample(15'd1234, -16'sd777, 1'b1, 1'b0);
    send_sample(15'd0, -16'sd32768, 1'b0, 1'b0);
    send_sample(15'd5000, 16'sd250, 1'b1, 1'b0);
  endtask

  // restart on a partial and on a wrapped window, negative means round toward zero
  task automatic test_restart();
    send_sample(15'd7, -16'sd3, 1'b1, 1'b1);
    send_sample(15'd8, -16'sd4, 1'b1, 1'b0);
    send_sample(15'd1, -16'sd1, 1'b1, 1'b1);
    send_sample(15'd2, -16'sd2, 1'b1, 1'b0);
    send_sample(15'd32767, 16'sd5, 1'b1, 1'b1);
  endtask

  // mostly online runs with random content, some restarts and offline noise
  task automatic test_random();
    logic [VOLT_W-1:0] volt;
    logic signed [CURR_W-1:0] curr;
    bit online;
    bit clear_hist;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a long stretch with both sides running flat out
      no_idle = (n >= 700 && n < 1000);
      case ($urandom_range(9))
        0:       volt = '0;
        1:       volt = '1;
        2:       volt = VOLT_W'($urandom_range(15));
        default: volt = VOLT_W'($urandom);
      endcase
      case ($urandom_range(9))
        0:       curr = -16'sd32768;
        1:       curr = 16'sd32767;
        2, 3:    curr = CURR_W'($urandom_range(31)) - 16'sd16;
        default: curr = CURR_W'($urandom);
      endcase
      online = ($urandom_range(99) >= 10);
      clear_hist = ($urandom_range(99) < 4);
      send_sample(volt, curr, online, clear_hist);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    stall_left = 0;
    no_idle = 1'b0;
    hist_slot = 0;
    hist_full = 1'b0;
    hist_vsum = 0;
    hist_csum = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_offline();
    test_restart();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
